### hw/rtl/mfa_pkg.sv
package mfa_pkg;

    localparam int unsigned FuncW = 3;
    localparam int unsigned FpW = 11;
    localparam int unsigned HalfW = 16;
    localparam int unsigned WholeOutW = 8;

    typedef enum logic [FuncW-1:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_NEG = 3'd3,
        FN_TOFP = 3'd4,
        FN_TOFIX = 3'd5
    } t_func;

    localparam logic [FpW-1:0] QNAN = 11'h3E0;
    localparam logic [FpW-1:0] POS_INF = 11'h3C0;
    localparam logic [FpW-1:0] NEG_INF = 11'h7C0;
    localparam logic [FpW-1:0] NEG_ZERO = 11'h400;
    localparam logic [FpW-1:0] SIGN_BIT = 11'h400;

    // Carried between stages: a finished result, or a value still to be rounded.
    typedef struct packed {
        logic [2:0]       func;
        logic             done;
        logic [FpW-1:0]   res;
        logic             sgn;
        logic signed [5:0] e;
        logic [6:0]       sig;
        logic             rnd;
        logic             sticky;
        logic [WholeOutW-1:0] whole;
        logic [HalfW-1:0] frac;
        logic             neg;
        logic             nan;
        logic             inf;
    } t_mid;

    function automatic logic [FpW-1:0] inf_of(input logic s);
        return s ? NEG_INF : POS_INF;
    endfunction

    function automatic logic [FpW-1:0] zero_of(input logic s);
        return s ? NEG_ZERO : '0;
    endfunction

endpackage

### hw/rtl/mfa_front.sv
module mfa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0]           i_func,
    input  logic [10:0]          i_a,
    input  logic [10:0]          i_b,
    input  logic [15:0]          i_whole,
    input  logic [15:0]          i_frac,
    input  logic                 i_neg,
    input  logic                 i_nan,
    input  logic                 i_inf,
    output logic                 o_valid,
    output mfa_pkg::t_mid        o_mid,
    output logic [13:0]          o_prod,
    output logic signed [5:0]    o_ea,
    output logic signed [5:0]    o_eb,
    output logic [20:0]          o_ma,
    output logic [20:0]          o_mb,
    output logic [31:0]          o_all
);
    import mfa_pkg::*;

    logic   r_valid;
    t_mid   r_mid, n_mid;
    logic [13:0] r_prod;
    logic [20:0] r_ma, r_mb;
    logic signed [5:0] r_ea, r_eb;
    logic [31:0] r_all;

    logic [10:0] b_eff;
    logic sa, sb;
    logic [3:0] xa, xb;
    logic [5:0] fa, fb;
    logic nan_a, nan_b, inf_a, inf_b, z_a, z_b;
    logic signed [5:0] ea, eb;
    logic [6:0] sig_a, sig_b;
    logic [3:0] xd;
    logic [24:0] fix_all;

    always_comb begin
        fix_all = {8'd0, 1'b1, i_a[5:0], 10'd0};
        if (i_a[9:6] >= 4'd7) fix_all = fix_all << (i_a[9:6] - 4'd7);
        else fix_all = fix_all >> (4'd7 - i_a[9:6]);
    end

    always_comb begin
        b_eff = (i_func == FN_SUB) ? (i_b ^ SIGN_BIT) : i_b;
        sa = i_a[10];
        sb = b_eff[10];
        xa = i_a[9:6];
        xb = b_eff[9:6];
        fa = i_a[5:0];
        fb = b_eff[5:0];
        nan_a = (xa == 4'hF) && (fa != '0);
        nan_b = (xb == 4'hF) && (fb != '0);
        inf_a = (xa == 4'hF) && (fa == '0);
        inf_b = (xb == 4'hF) && (fb == '0);
        z_a = (xa == '0) && (fa == '0);
        z_b = (xb == '0) && (fb == '0);
        ea = $signed({2'b00, xa}) - 6'sd7;
        eb = $signed({2'b00, xb}) - 6'sd7;
        sig_a = {1'b1, fa};
        sig_b = {1'b1, fb};
        n_mid = '0;
        n_mid.func = i_func;
        n_mid.sgn = sa ^ sb;
        case (i_func)
            FN_ADD, FN_SUB: begin
                if (nan_a || nan_b) begin
                    n_mid.done = 1'b1; n_mid.res = QNAN;
                end else if (inf_a) begin
                    n_mid.done = 1'b1;
                    n_mid.res = (inf_b && sa != sb) ? QNAN : inf_of(sa);
                end else if (inf_b) begin
                    n_mid.done = 1'b1; n_mid.res = inf_of(sb);
                end else if (z_a) begin
                    n_mid.done = 1'b1;
                    n_mid.res = z_b ? zero_of(sa & sb) : b_eff;
                end else if (z_b) begin
                    n_mid.done = 1'b1; n_mid.res = i_a;
                end
            end
            FN_MUL: begin
                if (nan_a || nan_b) begin
                    n_mid.done = 1'b1; n_mid.res = QNAN;
                end else if (inf_a) begin
                    n_mid.done = 1'b1; n_mid.res = z_b ? QNAN : inf_of(sa ^ sb);
                end else if (inf_b) begin
                    n_mid.done = 1'b1; n_mid.res = z_a ? QNAN : inf_of(sa ^ sb);
                end else if (z_a || z_b) begin
                    n_mid.done = 1'b1; n_mid.res = zero_of(sa ^ sb);
                end
                n_mid.e = ea + eb;
            end
            FN_NEG: begin
                n_mid.done = 1'b1; n_mid.res = i_a ^ SIGN_BIT;
            end
            FN_TOFP: begin
                n_mid.sgn = i_neg;
                if (i_nan) begin
                    n_mid.done = 1'b1; n_mid.res = QNAN;
                end else if (i_inf) begin
                    n_mid.done = 1'b1; n_mid.res = inf_of(i_neg);
                end else if ({i_whole, i_frac} == '0) begin
                    n_mid.done = 1'b1; n_mid.res = zero_of(i_neg);
                end
            end
            FN_TOFIX: begin
                n_mid.done = 1'b1;
                n_mid.neg = sa;
                if (xa == 4'hF) begin
                    n_mid.nan = (fa != '0);
                    n_mid.inf = (fa == '0);
                end else if (!z_a) begin
                    n_mid.whole = fix_all[23:16];
                    n_mid.frac = fix_all[15:0];
                end
            end
            default: begin
                n_mid.done = 1'b1;
            end
        endcase
        xd = (xa > xb) ? (xa - xb) : (xb - xa);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_mid <= n_mid;
            r_prod <= 14'(sig_a) * 14'(sig_b);
            r_ea <= ea;
            r_eb <= eb;
            r_ma <= (xa > xb) ? (21'(sig_a) << xd) : 21'(sig_a);
            r_mb <= (xb > xa) ? (21'(sig_b) << xd) : 21'(sig_b);
            r_all <= {i_whole, i_frac};
        end
    end

    assign o_valid = r_valid;
    assign o_mid = r_mid;
    assign o_prod = r_prod;
    assign o_ea = r_ea;
    assign o_eb = r_eb;
    assign o_ma = r_ma;
    assign o_mb = r_mb;
    assign o_all = r_all;
endmodule

### hw/rtl/mfa_norm.sv
module mfa_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mfa_pkg::t_mid     i_mid,
    input  logic [13:0]       i_prod,
    input  logic signed [5:0] i_ea,
    input  logic signed [5:0] i_eb,
    input  logic [20:0]       i_ma,
    input  logic [20:0]       i_mb,
    input  logic [31:0]       i_all,
    output logic              o_valid,
    output mfa_pkg::t_mid     o_mid
);
    import mfa_pkg::*;

    logic r_valid;
    t_mid r_mid, n_mid;

    logic sa, sb;
    logic signed [22:0] sum;
    logic [21:0] mag;
    logic [21:0] msh;
    logic [4:0] lz;
    logic [4:0] hp;
    logic signed [6:0] ee;
    logic [13:0] pm;
    logic [4:0] p;
    logic [31:0] sh;

    always_comb begin
        n_mid = i_mid;
        sa = 1'b0; sb = 1'b0; sum = '0; mag = '0; msh = '0; lz = '0; hp = '0;
        ee = '0; pm = '0; p = '0; sh = '0;
        if (!i_mid.done) begin
            case (i_mid.func)
                FN_ADD, FN_SUB: begin
                    // sign of a is the product-sign xor b sign; recovered here.
                    sb = i_mid.res[0];
                    sa = i_mid.sgn ^ sb;
                    sum = (sa ? -$signed({2'b0, i_ma}) : $signed({2'b0, i_ma}))
                        + (sb ? -$signed({2'b0, i_mb}) : $signed({2'b0, i_mb}));
                    mag = sum[22] ? 22'(-sum) : 22'(sum);
                    n_mid.sgn = sum[22];
                    ee = 7'((i_ea < i_eb) ? i_ea : i_eb);
                    if (mag == '0) begin
                        n_mid.done = 1'b1; n_mid.res = '0;
                    end else if (mag >= 22'h40) begin
                        for (int k = 0; k < 22; k++) if (mag[k]) hp = 5'(k);
                        ee = ee + 7'(hp) - 7'sd6;
                        msh = mag << (5'd21 - hp);
                        n_mid.sig = msh[21:15];
                        n_mid.rnd = msh[14];
                        n_mid.sticky = msh[13:0] != '0;
                        if (ee > 7'sd7) begin
                            n_mid.done = 1'b1; n_mid.res = inf_of(sum[22]);
                        end
                    end else begin
                        for (int k = 0; k < 7; k++) if (mag[k]) hp = 5'(k);
                        lz = 5'd6 - hp;
                        ee = ee - 7'(lz);
                        n_mid.sig = 7'(mag << lz);
                        if (ee < -7'sd6) begin
                            n_mid.done = 1'b1; n_mid.res = zero_of(sum[22]);
                        end
                    end
                    n_mid.e = 6'(ee);
                end
                FN_MUL: begin
                    ee = 7'(i_mid.e);
                    pm = i_prod;
                    if (pm[13]) begin
                        ee = ee + 7'sd1;
                        n_mid.sig = pm[13:7];
                        n_mid.rnd = pm[6];
                        n_mid.sticky = pm[5:0] != '0;
                    end else begin
                        n_mid.sig = pm[12:6];
                        n_mid.rnd = pm[5];
                        n_mid.sticky = pm[4:0] != '0;
                    end
                    n_mid.e = 6'(ee);
                    if (ee > 7'sd7) begin
                        n_mid.done = 1'b1; n_mid.res = inf_of(i_mid.sgn);
                    end else if (ee < -7'sd6) begin
                        n_mid.done = 1'b1; n_mid.res = zero_of(i_mid.sgn);
                    end
                end
                FN_TOFP: begin
                    for (int k = 0; k < 32; k++) if (i_all[k]) p = 5'(k);
                    ee = 7'(p) - 7'sd16;
                    sh = i_all << (5'd31 - p);
                    n_mid.sig = sh[31:25];
                    n_mid.rnd = sh[24];
                    n_mid.sticky = sh[23:0] != '0;
                    n_mid.e = 6'(ee);
                    if (ee > 7'sd7) begin
                        n_mid.done = 1'b1; n_mid.res = inf_of(i_mid.sgn);
                    end else if (ee < -7'sd6) begin
                        n_mid.done = 1'b1; n_mid.res = zero_of(i_mid.sgn);
                    end
                end
                default: begin
                    n_mid.done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_valid;
    assign o_mid = r_mid;
endmodule

### hw/rtl/mfa_round.sv
module mfa_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mfa_pkg::t_mid i_mid,
    output logic          o_valid,
    output logic [10:0]   o_small_result,
    output logic [7:0]    o_out_whole,
    output logic [15:0]   o_out_fraction,
    output logic          o_out_negative,
    output logic          o_out_nan,
    output logic          o_out_infinity
);
    import mfa_pkg::*;

    logic r_valid;
    logic [10:0] r_res;
    logic [7:0] r_whole;
    logic [15:0] r_frac;
    logic r_neg, r_nan, r_inf;
    logic [10:0] n_res;
    logic [7:0] sg;
    logic signed [5:0] ee;
    logic [3:0] xf;

    always_comb begin
        sg = {1'b0, i_mid.sig} + 8'(i_mid.rnd & (i_mid.sticky | i_mid.sig[0]));
        ee = i_mid.e;
        if (sg[7]) begin
            sg = sg >> 1;
            ee = ee + 6'sd1;
        end
        xf = 4'(ee + 6'sd7);
        if (i_mid.done) n_res = i_mid.res;
        else if (ee > 6'sd7) n_res = inf_of(i_mid.sgn);
        else n_res = {i_mid.sgn, xf, sg[5:0]};
        if (i_mid.func == FN_TOFIX || i_mid.func > FN_TOFIX) n_res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_res <= n_res;
            r_whole <= i_mid.whole;
            r_frac <= i_mid.frac;
            r_neg <= i_mid.neg;
            r_nan <= i_mid.nan;
            r_inf <= i_mid.inf;
        end
    end

    assign o_valid = r_valid;
    assign o_small_result = r_res;
    assign o_out_whole = r_whole;
    assign o_out_fraction = r_frac;
    assign o_out_negative = r_neg;
    assign o_out_nan = r_nan;
    assign o_out_infinity = r_inf;

    property p_fix_clean;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_nan && r_inf);
    endproperty
    a_fix_clean: assert property (p_fix_clean) else $error("nan and infinity both set");

    property p_fix_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_nan || r_inf)) |-> (r_whole == '0 && r_frac == '0 && r_res == '0);
    endproperty
    a_fix_zero: assert property (p_fix_zero) else $error("special value has magnitude");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (!i_en) |=> $stable(r_res);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while held");
endmodule

### hw/rtl/minifloat_11bit_arith_convert.sv
// Minifloat (1-4-6, bias 7) add, subtract, multiply, negate, 16.16 to float and float to 8.16.
// Input channel: i_valid with o_stall, carrying func and the operand fields.
// Output channel: o_valid with i_stall, carrying one result item per input item.
// An item is accepted on a rising edge where valid is high and stall is low.
// There are three register stages: decode and multiply/align, normalise, then
// round and pack. An accepted item moves through them in that order and o_valid
// rises when it reaches the last; one item may enter every cycle unless stalled.
// When the receiver stalls while the output register is full, the whole pipeline
// holds and o_stall follows i_stall, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties every stage; payload is not cleared.
module minifloat_11bit_arith_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [10:0] i_operand_a,
    input  logic [10:0] i_operand_b,
    input  logic [15:0] i_in_whole,
    input  logic [15:0] i_in_fraction,
    input  logic        i_in_negative,
    input  logic        i_in_nan,
    input  logic        i_in_infinity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_small_result,
    output logic [7:0]  o_out_whole,
    output logic [15:0] o_out_fraction,
    output logic        o_out_negative,
    output logic        o_out_nan,
    output logic        o_out_infinity
);
    import mfa_pkg::*;

    logic en;
    logic v1, v2;
    t_mid m1, m1x, m2;
    logic [13:0] prod;
    logic [20:0] ma, mb;
    logic signed [5:0] ea, eb;
    logic [31:0] all_bits;
    logic r_sgn_b;

    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    mfa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid && en),
        .i_func(i_func), .i_a(i_operand_a), .i_b(i_operand_b),
        .i_whole(i_in_whole), .i_frac(i_in_fraction), .i_neg(i_in_negative),
        .i_nan(i_in_nan), .i_inf(i_in_infinity),
        .o_valid(v1), .o_mid(m1), .o_prod(prod), .o_ea(ea), .o_eb(eb),
        .o_ma(ma), .o_mb(mb), .o_all(all_bits)
    );

    // Stage two needs the sign of b; it rides in the spare result bit.
    always_comb begin
        m1x = m1;
        if (!m1.done) m1x.res = 11'(r_sgn_b);
    end

    always_ff @(posedge i_clk) begin
        if (en) r_sgn_b <= (i_func == FN_SUB) ? !i_operand_b[10] : i_operand_b[10];
    end

    mfa_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1), .i_mid(m1x),
        .i_prod(prod), .i_ea(ea), .i_eb(eb), .i_ma(ma), .i_mb(mb), .i_all(all_bits),
        .o_valid(v2), .o_mid(m2)
    );

    mfa_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v2), .i_mid(m2),
        .o_valid(o_valid), .o_small_result(o_small_result),
        .o_out_whole(o_out_whole), .o_out_fraction(o_out_fraction),
        .o_out_negative(o_out_negative), .o_out_nan(o_out_nan),
        .o_out_infinity(o_out_infinity)
    );
endmodule
